### sv/vcsf_pkg.sv
// Shared types and constants for the VIF code stream framer.
// Used by every module of the block; no dependencies of its own.
package vcsf_pkg;

  localparam int unsigned WORD_W  = 32;
  localparam int unsigned COUNT_W = 9;
  localparam int unsigned REM_W   = 11;
  localparam int unsigned CMD_W   = 7;

  // command codes, interrupt bit already dropped
  localparam logic [CMD_W-1:0] CMD_NOP         = 7'h00;
  localparam logic [CMD_W-1:0] CMD_STCYCL      = 7'h01;
  localparam logic [CMD_W-1:0] CMD_IMM_A_FIRST = 7'h02;
  localparam logic [CMD_W-1:0] CMD_IMM_A_LAST  = 7'h07;
  localparam logic [CMD_W-1:0] CMD_IMM_B_FIRST = 7'h10;
  localparam logic [CMD_W-1:0] CMD_IMM_B_LAST  = 7'h17;
  localparam logic [CMD_W-1:0] CMD_STMASK      = 7'h20;
  localparam logic [CMD_W-1:0] CMD_STROW       = 7'h30;
  localparam logic [CMD_W-1:0] CMD_STCOL       = 7'h31;
  localparam logic [CMD_W-1:0] CMD_UNPACK      = 7'h60;
  localparam logic [CMD_W-1:0] CMD_TOP         = 7'h7F;

  // vl codes of an UNPACK
  localparam logic [1:0] VL_32   = 2'd0;
  localparam logic [1:0] VL_16   = 2'd1;
  localparam logic [1:0] VL_8    = 2'd2;
  localparam logic [1:0] VL_PACK = 2'd3;

  localparam logic [REM_W-1:0] STMASK_WORDS = 11'd1;
  localparam logic [REM_W-1:0] STROW_WORDS  = 11'd4;
  localparam logic [8:0]       ZERO_MEANS   = 9'd256;

  typedef enum logic [1:0] {
    PH_CMD     = 2'd0,
    PH_INLINE  = 2'd1,
    PH_PAYLOAD = 2'd2
  } phase_t;

  typedef enum logic [1:0] {
    KIND_CMD     = 2'd0,
    KIND_INLINE  = 2'd1,
    KIND_PAYLOAD = 2'd2,
    KIND_IGNORED = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    SHAPE_OTHER     = 3'd0,
    SHAPE_ANCHORS   = 3'd1,
    SHAPE_POSITIONS = 3'd2,
    SHAPE_COLORS    = 3'd3,
    SHAPE_UVS       = 3'd4
  } shape_t;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_FILL    = 3'd1,
    ST_PACKED  = 3'd2,
    ST_UNKNOWN = 3'd3,
    ST_TRUNC   = 3'd4
  } status_t;

  // decoded command word
  typedef struct packed {
    logic               starts;   // command opens a data run
    phase_t             phase;
    logic [REM_W-1:0]   rem;
    shape_t             shape;
    logic [COUNT_W-1:0] count;
    status_t            status;
    logic               halt;
  } dec_t;

  // one result item
  typedef struct packed {
    kind_t              word_kind;
    shape_t             unpack_shape;
    logic [COUNT_W-1:0] element_count;
    logic [REM_W-1:0]   words_remaining;
    status_t            status;
    logic               halted;
  } res_t;

endpackage

### sv/vif_code_stream_framer.sv
// Top level of the VIF code stream framer: input register, walker, result register.
// Depends on vcsf_pkg, vcsf_in_stage and vcsf_walker.
//
//   channel  direction  handshake              payload
//   in_      request    in_valid / in_stall    in_word[31:0], in_last
//   out_     result     out_valid / out_stall  word_kind, unpack_shape, element_count,
//                                              words_remaining, status, halted
//
// Each word passes from acceptance through the input register, then through the
// decode and walk logic into the result register. One word is accepted every cycle
// while in_stall is low; the walk state register is the only loop.
// Reset (rst_n low, synchronous) empties both registers and returns the walk
// to expecting a command. A stall on out_ holds the result; in_stall rises
// only when the input register holds a word that cannot move on.
module vif_code_stream_framer (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [vcsf_pkg::WORD_W-1:0]  in_word,
  input  logic                         in_last,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [1:0]                   out_word_kind,
  output logic [2:0]                   out_unpack_shape,
  output logic [vcsf_pkg::COUNT_W-1:0] out_element_count,
  output logic [vcsf_pkg::REM_W-1:0]   out_words_remaining,
  output logic [2:0]                   out_status,
  output logic                         out_halted
);
  import vcsf_pkg::*;

  logic              stage_valid;
  logic [WORD_W-1:0] stage_word;
  logic              stage_last;
  logic              out_free;
  logic              fire;
  res_t              res;
  logic              out_valid_r;
  res_t              out_res_r;

  // result slot can take a word when empty or being emptied
  assign out_free = ~out_valid_r | ~out_stall;
  assign fire     = stage_valid & out_free;

  vcsf_in_stage u_in (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_word     (in_word),
    .in_last     (in_last),
    .out_free    (out_free),
    .stage_valid (stage_valid),
    .stage_word  (stage_word),
    .stage_last  (stage_last)
  );

  // walk state advances only when the word moves into the result register
  vcsf_walker u_walk (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (fire),
    .word  (stage_word),
    .last  (stage_last),
    .res   (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= stage_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_res_r <= res;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_word_kind       = out_res_r.word_kind;
  assign out_unpack_shape    = out_res_r.unpack_shape;
  assign out_element_count   = out_res_r.element_count;
  assign out_words_remaining = out_res_r.words_remaining;
  assign out_status          = out_res_r.status;
  assign out_halted          = out_res_r.halted;

  // any non-ok status stops the walk on that same word
  a_status_halts : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_OK |-> out_halted)
    else $error("non-ok status without halt");

  // ignored words carry no shape, count or remaining words
  a_ignored_clean : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_word_kind == KIND_IGNORED |->
      out_halted && out_unpack_shape == SHAPE_OTHER &&
      out_element_count == '0 && out_words_remaining == '0)
    else $error("ignored word carries payload fields");

  // element count appears only on an UNPACK command word
  a_count_on_cmd : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_element_count != '0 |->
      out_word_kind == KIND_CMD && out_unpack_shape != SHAPE_OTHER ||
      out_valid && out_element_count != '0 && out_word_kind == KIND_CMD)
    else $error("element count outside an unpack command word");

  // the input side stalls only behind a held word
  a_stall_cause : assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> stage_valid && out_valid && out_stall)
    else $error("input stalled without a held word");

endmodule

### sv/vcsf_in_stage.sv
// Input register of the VIF code stream framer: holds one word and its flag.
// Depends on vcsf_pkg.
module vcsf_in_stage (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [vcsf_pkg::WORD_W-1:0] in_word,
  input  logic                        in_last,
  input  logic                        out_free,
  output logic                        stage_valid,
  output logic [vcsf_pkg::WORD_W-1:0] stage_word,
  output logic                        stage_last
);
  import vcsf_pkg::*;

  logic                valid_r;
  logic [WORD_W-1:0]   word_r;
  logic                last_r;

  // hold while the held request cannot move on
  assign in_stall = valid_r & ~out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (!in_stall) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      word_r <= in_word;
      last_r <= in_last;
    end
  end

  assign stage_valid = valid_r;
  assign stage_word  = word_r;
  assign stage_last  = last_r;

endmodule

### sv/vcsf_cmd_decode.sv
// Command word decoder: command class, data length, shape and halt reason.
// Depends on vcsf_pkg.
module vcsf_cmd_decode (
  input  logic [vcsf_pkg::WORD_W-1:0] word,
  output vcsf_pkg::dec_t              dec
);
  import vcsf_pkg::*;

  logic [7:0]         imm_lo;
  logic [7:0]         imm_hi;
  logic [7:0]         num;
  logic [CMD_W-1:0]   cmd;
  logic [1:0]         vn;
  logic [1:0]         vl;
  logic [8:0]         cl;
  logic [8:0]         wl;
  logic [COUNT_W-1:0] n;
  logic [11:0]        prod;
  logic [11:0]        words;
  shape_t             shape;

  assign imm_lo = word[7:0];
  assign imm_hi = word[15:8];
  assign num    = word[23:16];
  assign cmd    = word[30:24];
  assign vn     = cmd[3:2];
  assign vl     = cmd[1:0];

  assign cl = (imm_lo == 8'd0) ? ZERO_MEANS : {1'b0, imm_lo};
  assign wl = (imm_hi == 8'd0) ? ZERO_MEANS : {1'b0, imm_hi};
  assign n  = (num == 8'd0) ? ZERO_MEANS : {1'b0, num};

  // elements times components, then round up to whole words
  assign prod = 12'(n) * 12'({1'b0, vn} + 3'd1);

  always_comb begin
    unique case (vl)
      VL_32:   words = prod;
      VL_16:   words = (prod + 12'd1) >> 1;
      default: words = (prod + 12'd3) >> 2;
    endcase
  end

  always_comb begin
    shape = SHAPE_OTHER;
    if (vn == 2'd3 && vl == VL_32)      shape = SHAPE_ANCHORS;
    else if (vn == 2'd2 && vl == VL_16) shape = SHAPE_POSITIONS;
    else if (vn == 2'd2 && vl == VL_8)  shape = SHAPE_COLORS;
    else if (vn == 2'd1 && vl == VL_16) shape = SHAPE_UVS;
  end

  always_comb begin
    dec = '0;
    dec.phase  = PH_CMD;
    dec.shape  = SHAPE_OTHER;
    dec.status = ST_OK;
    unique case (cmd) inside
      CMD_NOP, [CMD_IMM_A_FIRST:CMD_IMM_A_LAST], [CMD_IMM_B_FIRST:CMD_IMM_B_LAST]: begin
        dec.starts = 1'b0;
      end
      CMD_STCYCL: begin
        // fill mode: write length above cycle length
        if (wl > cl) begin
          dec.status = ST_FILL;
          dec.halt   = 1'b1;
        end
      end
      CMD_STMASK, CMD_STROW, CMD_STCOL: begin
        dec.starts = 1'b1;
        dec.phase  = PH_INLINE;
        dec.rem    = (cmd == CMD_STMASK) ? STMASK_WORDS : STROW_WORDS;
      end
      [CMD_UNPACK:CMD_TOP]: begin
        if (vl == VL_PACK) begin
          dec.status = ST_PACKED;
          dec.halt   = 1'b1;
        end else begin
          dec.starts = 1'b1;
          dec.phase  = PH_PAYLOAD;
          dec.rem    = words[REM_W-1:0];
          dec.shape  = shape;
          dec.count  = n;
        end
      end
      default: begin
        dec.status = ST_UNKNOWN;
        dec.halt   = 1'b1;
      end
    endcase
  end

endmodule

### sv/vcsf_walker.sv
// Stream walk state and per-word labelling of the VIF code stream framer.
// Depends on vcsf_pkg and vcsf_cmd_decode.
module vcsf_walker (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        fire,
  input  logic [vcsf_pkg::WORD_W-1:0] word,
  input  logic                        last,
  output vcsf_pkg::res_t              res
);
  import vcsf_pkg::*;

  phase_t           phase_r, phase_nxt;
  logic [REM_W-1:0] left_r, left_nxt;
  shape_t           shape_r, shape_nxt;
  logic             stopped_r, stopped_nxt;

  dec_t             dec;
  logic [REM_W-1:0] data_rem;
  logic             in_data;

  vcsf_cmd_decode u_dec (
    .word (word),
    .dec  (dec)
  );

  assign in_data  = (phase_r == PH_INLINE) || (phase_r == PH_PAYLOAD);
  assign data_rem = (left_r != '0) ? left_r - REM_W'(1) : '0;

  // label the word
  always_comb begin
    res = '0;
    res.word_kind    = KIND_CMD;
    res.unpack_shape = SHAPE_OTHER;
    res.status       = ST_OK;
    if (stopped_r) begin
      res.word_kind = KIND_IGNORED;
      res.halted    = 1'b1;
    end else if (in_data) begin
      res.word_kind       = (phase_r == PH_INLINE) ? KIND_INLINE : KIND_PAYLOAD;
      res.unpack_shape    = (phase_r == PH_PAYLOAD) ? shape_r : SHAPE_OTHER;
      res.words_remaining = data_rem;
      if (data_rem != '0 && last) begin
        res.status = ST_TRUNC;
        res.halted = 1'b1;
      end
    end else begin
      res.unpack_shape    = dec.shape;
      res.element_count   = dec.count;
      res.words_remaining = dec.rem;
      res.status          = dec.status;
      res.halted          = dec.halt;
      if (!dec.halt && dec.rem != '0 && last) begin
        res.status = ST_TRUNC;
        res.halted = 1'b1;
      end
    end
  end

  // advance the walk
  always_comb begin
    phase_nxt   = phase_r;
    left_nxt    = left_r;
    shape_nxt   = shape_r;
    stopped_nxt = stopped_r;
    if (fire) begin
      if (!stopped_r) begin
        if (in_data) begin
          left_nxt = data_rem;
          if (data_rem == '0) begin
            phase_nxt = PH_CMD;
            shape_nxt = SHAPE_OTHER;
          end
        end else if (!dec.halt && dec.starts) begin
          phase_nxt = dec.phase;
          left_nxt  = dec.rem;
          shape_nxt = dec.shape;
        end
        if (res.halted) stopped_nxt = 1'b1;
      end
      // drop all walk state at the end of a stream
      if (last) begin
        phase_nxt   = PH_CMD;
        left_nxt    = '0;
        shape_nxt   = SHAPE_OTHER;
        stopped_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_CMD;
      left_r    <= '0;
      shape_r   <= SHAPE_OTHER;
      stopped_r <= 1'b0;
    end else begin
      phase_r   <= phase_nxt;
      left_r    <= left_nxt;
      shape_r   <= shape_nxt;
      stopped_r <= stopped_nxt;
    end
  end

endmodule

### dv/vcsf_checker.sv
`timescale 1ns / 100ps
// Checker for the VIF code stream framer: watches the request and result channels,
// predicts the label of every accepted word and compares it field by field.
// Depends on vcsf_pkg for widths, codes and the result layout.
module vcsf_checker (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  input  logic                         in_stall,
  input  logic [vcsf_pkg::WORD_W-1:0]  in_word,
  input  logic                         in_last,
  input  logic                         out_valid,
  input  logic                         out_stall,
  input  logic [1:0]                   out_word_kind,
  input  logic [2:0]                   out_unpack_shape,
  input  logic [vcsf_pkg::COUNT_W-1:0] out_element_count,
  input  logic [vcsf_pkg::REM_W-1:0]   out_words_remaining,
  input  logic [2:0]                   out_status,
  input  logic                         out_halted,
  output logic [31:0]                  mismatches,
  output logic [31:0]                  labels_pending
);
  import vcsf_pkg::*;

  phase_t           walk_phase_q  = PH_CMD;
  logic [REM_W-1:0] data_left_q   = '0;
  shape_t           run_shape_q   = SHAPE_OTHER;
  logic             stopped_q     = 1'b0;
  res_t             expected_labels[$];
  int unsigned      err_count     = 0;
  int unsigned      label_no      = 0;

  assign mismatches = err_count;

  task automatic report_mismatch(input string msg);
    err_count++;
    if (err_count <= 40) $display("[%0t] label %0d: %s", $time, label_no, msg);
  endtask

  function automatic shape_t shape_for(logic [1:0] vn, logic [1:0] vl);
    if (vn == 2'd3 && vl == VL_32) return SHAPE_ANCHORS;
    if (vn == 2'd2 && vl == VL_16) return SHAPE_POSITIONS;
    if (vn == 2'd2 && vl == VL_8)  return SHAPE_COLORS;
    if (vn == 2'd1 && vl == VL_16) return SHAPE_UVS;
    return SHAPE_OTHER;
  endfunction

  function automatic int unsigned component_bytes(logic [1:0] vl);
    if (vl == VL_32) return 4;
    if (vl == VL_16) return 2;
    return 1;
  endfunction

  // Label one stream word and advance the walk.
  task automatic frame_word(input logic [WORD_W-1:0] w, input logic lst, output res_t r);
    logic [CMD_W-1:0] cmd;
    logic [8:0]       cl, wl;
    logic [1:0]       vn, vl;
    logic [REM_W-1:0] rem;
    int unsigned      n, nbytes;
    r   = '0;
    rem = '0;
    cmd = w[30:24];
    if (stopped_q) begin
      r.word_kind = KIND_IGNORED;
      r.halted    = 1'b1;
    end else if (walk_phase_q == PH_INLINE || walk_phase_q == PH_PAYLOAD) begin
      r.word_kind    = (walk_phase_q == PH_INLINE) ? KIND_INLINE : KIND_PAYLOAD;
      r.unpack_shape = (walk_phase_q == PH_PAYLOAD) ? run_shape_q : SHAPE_OTHER;
      rem            = (data_left_q != '0) ? data_left_q - 1'b1 : '0;
      data_left_q    = rem;
      if (rem == '0) begin
        walk_phase_q = PH_CMD;
        run_shape_q  = SHAPE_OTHER;
      end else if (lst) begin
        r.status = ST_TRUNC;
        r.halted = 1'b1;
      end
    end else begin
      r.word_kind = KIND_CMD;
      if (cmd == CMD_NOP || (cmd >= CMD_IMM_A_FIRST && cmd <= CMD_IMM_A_LAST) ||
          (cmd >= CMD_IMM_B_FIRST && cmd <= CMD_IMM_B_LAST)) begin
        // immediate only: nothing follows
      end else if (cmd == CMD_STCYCL) begin
        cl = (w[7:0] == 8'd0)  ? ZERO_MEANS : {1'b0, w[7:0]};
        wl = (w[15:8] == 8'd0) ? ZERO_MEANS : {1'b0, w[15:8]};
        if (wl > cl) begin
          r.status = ST_FILL;
          r.halted = 1'b1;
        end
      end else if (cmd == CMD_STMASK || cmd == CMD_STROW || cmd == CMD_STCOL) begin
        rem          = (cmd == CMD_STMASK) ? STMASK_WORDS : STROW_WORDS;
        walk_phase_q = PH_INLINE;
        data_left_q  = rem;
        run_shape_q  = SHAPE_OTHER;
      end else if (cmd >= CMD_UNPACK) begin
        vn = cmd[3:2];
        vl = cmd[1:0];
        if (vl == VL_PACK) begin
          r.status = ST_PACKED;
          r.halted = 1'b1;
        end else begin
          n               = (w[23:16] == 8'd0) ? 256 : w[23:16];
          nbytes          = n * (vn + 1) * component_bytes(vl);
          rem             = REM_W'((nbytes + 3) >> 2);
          r.unpack_shape  = shape_for(vn, vl);
          r.element_count = COUNT_W'(n);
          walk_phase_q    = PH_PAYLOAD;
          data_left_q     = rem;
          run_shape_q     = r.unpack_shape;
        end
      end else begin
        r.status = ST_UNKNOWN;
        r.halted = 1'b1;
      end
      if (!r.halted && rem != '0 && lst) begin
        r.status = ST_TRUNC;
        r.halted = 1'b1;
      end
    end
    r.words_remaining = rem;
    if (r.halted) stopped_q = 1'b1;
    if (lst) begin
      walk_phase_q = PH_CMD;
      data_left_q  = '0;
      run_shape_q  = SHAPE_OTHER;
      stopped_q    = 1'b0;
    end
  endtask

  always @(posedge clk) begin : track
    res_t want;
    if (!rst_n) begin
      walk_phase_q = PH_CMD;
      data_left_q  = '0;
      run_shape_q  = SHAPE_OTHER;
      stopped_q    = 1'b0;
      expected_labels.delete();
    end else begin
      if (in_valid && !in_stall) begin
        frame_word(in_word, in_last, want);
        expected_labels.insert(expected_labels.size(), want);
      end
      if (out_valid && !out_stall) begin
        if (expected_labels.size() == 0) begin
          report_mismatch("result with no request waiting");
        end else begin
          want = expected_labels.pop_front();
          if (out_word_kind !== want.word_kind)
            report_mismatch($sformatf("word_kind %0d, want %0d", out_word_kind, want.word_kind));
          if (out_unpack_shape !== want.unpack_shape)
            report_mismatch($sformatf("unpack_shape %0d, want %0d",
                                      out_unpack_shape, want.unpack_shape));
          if (out_element_count !== want.element_count)
            report_mismatch($sformatf("element_count %0d, want %0d",
                                      out_element_count, want.element_count));
          if (out_words_remaining !== want.words_remaining)
            report_mismatch($sformatf("words_remaining %0d, want %0d",
                                      out_words_remaining, want.words_remaining));
          if (out_status !== want.status)
            report_mismatch($sformatf("status %0d, want %0d", out_status, want.status));
          if (out_halted !== want.halted)
            report_mismatch($sformatf("halted %0d, want %0d", out_halted, want.halted));
        end
        label_no++;
      end
    end
    labels_pending <= expected_labels.size();
  end

endmodule

### dv/vif_code_stream_framer_tb.sv
`timescale 1ns / 100ps
// Top of the VIF code stream framer testbench: clock, reset, stream stimulus and verdict.
// Depends on vcsf_pkg, the framer RTL and vcsf_checker, which does all the comparing.
module vif_code_stream_framer_tb;
  import vcsf_pkg::*;

  localparam int unsigned WORD_TARGET = 1800;
  // cycles with no handshake on either side before the run is given up
  localparam int unsigned STALL_LIMIT = 5000;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  logic [WORD_W-1:0]  in_word;
  logic               in_last;
  logic               out_valid;
  logic               out_stall;
  logic [1:0]         out_word_kind;
  logic [2:0]         out_unpack_shape;
  logic [COUNT_W-1:0] out_element_count;
  logic [REM_W-1:0]   out_words_remaining;
  logic [2:0]         out_status;
  logic               out_halted;
  logic [31:0]        mismatches;
  logic [31:0]        labels_pending;

  logic [WORD_W-1:0]  frame[$];      // words of the stream being built
  bit                 quiet = 1'b0;  // no idling on either side while set
  int unsigned        words_sent = 0;
  int unsigned        streams_sent = 0;
  int unsigned        cut_streams = 0;
  int unsigned        noise_streams = 0;
  int unsigned        drains = 0;

  vif_code_stream_framer i_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_word             (in_word),
    .in_last             (in_last),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_word_kind       (out_word_kind),
    .out_unpack_shape    (out_unpack_shape),
    .out_element_count   (out_element_count),
    .out_words_remaining (out_words_remaining),
    .out_status          (out_status),
    .out_halted          (out_halted)
  );

  vcsf_checker i_checker (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_word             (in_word),
    .in_last             (in_last),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_word_kind       (out_word_kind),
    .out_unpack_shape    (out_unpack_shape),
    .out_element_count   (out_element_count),
    .out_words_remaining (out_words_remaining),
    .out_status          (out_status),
    .out_halted          (out_halted),
    .mismatches          (mismatches),
    .labels_pending      (labels_pending)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Result side: stall at random on every falling edge, except in the quiet stretch.
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      out_stall <= !quiet && ($urandom_range(0, 99) < 16);
    end
  end

  // Watchdog: give up once neither channel has moved for too long.
  initial begin : watchdog
    int unsigned dead_cycles;
    dead_cycles = 0;
    while (dead_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) dead_cycles = 0;
      else dead_cycles++;
    end
    $display("[%0t] watchdog: no handshake for %0d cycles", $time, STALL_LIMIT);
    $display("FAILED: results differ");
    $finish;
  end

  // Offer one request from a falling edge and hold it until accepted; return on
  // the falling edge after acceptance so that the next request can follow at once.
  task automatic send_word(input logic [WORD_W-1:0] w, input logic lst);
    while (!quiet && $urandom_range(0, 99) < 16) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    in_last  <= lst;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
    words_sent++;
  endtask

  // Send the built stream, flagging its final word as last.
  task automatic send_frame();
    foreach (frame[i]) send_word(frame[i], i == frame.size() - 1);
    streams_sent++;
    quiet = (words_sent >= 700 && words_sent < 1000);
  endtask

  // Hold the request side low until every label is back.
  task automatic drain_labels();
    in_valid <= 1'b0;
    while (labels_pending != 0) @(negedge clk);
    @(negedge clk);
    drains++;
  endtask

  function automatic logic [WORD_W-1:0] cmd_word(logic [CMD_W-1:0] cmd, logic [7:0] num,
                                                 logic [7:0] hi, logic [7:0] lo);
    logic irq;
    irq = 1'($urandom_range(0, 1));
    return {irq, cmd, num, hi, lo};
  endfunction

  // Build one stream of random commands, some of them halting; now and then
  // cut the final data run short, or send plain noise instead.
  task automatic build_stream();
    int unsigned      n_cmds, pick, data_n, last_data, n, cb;
    logic [CMD_W-1:0] cmd;
    logic [7:0]       num, lo, hi, swap;
    logic [8:0]       cle, wle;
    logic [1:0]       vn, vl;
    bit               halting;
    frame.delete();
    last_data = 0;
    halting   = 1'b0;
    if ($urandom_range(0, 99) < 5) begin
      repeat ($urandom_range(1, 6)) frame.insert(frame.size(), $urandom);
      noise_streams++;
      return;
    end
    n_cmds = $urandom_range(1, 6);
    for (int c = 0; c < n_cmds && !halting; c++) begin
      pick   = $urandom_range(0, 99);
      data_n = 0;
      num    = 8'($urandom);
      lo     = 8'($urandom);
      hi     = 8'($urandom);
      if (pick < 12) begin
        case ($urandom_range(0, 2))
          0:       cmd = CMD_NOP;
          1:       cmd = CMD_IMM_A_FIRST + 7'($urandom_range(0, 5));
          default: cmd = CMD_IMM_B_FIRST + 7'($urandom_range(0, 7));
        endcase
      end else if (pick < 22) begin
        // mostly a legal cycle setting, fill mode about one time in five
        cmd = CMD_STCYCL;
        cle = (lo == 8'd0) ? ZERO_MEANS : {1'b0, lo};
        wle = (hi == 8'd0) ? ZERO_MEANS : {1'b0, hi};
        if (($urandom_range(0, 99) < 20) != (wle > cle) && wle != cle) begin
          swap = lo;
          lo   = hi;
          hi   = swap;
        end
        cle     = (lo == 8'd0) ? ZERO_MEANS : {1'b0, lo};
        wle     = (hi == 8'd0) ? ZERO_MEANS : {1'b0, hi};
        halting = (wle > cle);
      end else if (pick < 32) begin
        cmd    = CMD_STMASK;
        data_n = 32'(STMASK_WORDS);
      end else if (pick < 44) begin
        cmd    = ($urandom_range(0, 1) == 1) ? CMD_STCOL : CMD_STROW;
        data_n = 32'(STROW_WORDS);
      end else if (pick < 92) begin
        // bias towards the four named shapes; counts stay small bar a few
        case ($urandom_range(0, 9))
          0:       begin vn = 2'd3; vl = VL_32; end
          1:       begin vn = 2'd2; vl = VL_16; end
          2:       begin vn = 2'd2; vl = VL_8;  end
          3, 4:    begin vn = 2'd1; vl = VL_16; end
          default: begin vn = 2'($urandom); vl = 2'($urandom_range(0, 2)); end
        endcase
        if ($urandom_range(0, 99) < 5) vl = VL_PACK;
        cmd  = CMD_UNPACK | {2'b00, 1'($urandom_range(0, 1)), vn, vl};
        pick = $urandom_range(0, 99);
        num  = (pick < 1) ? 8'd0 : (pick < 2) ? 8'd255 : 8'($urandom_range(1, 12));
        if (vl == VL_PACK) begin
          halting = 1'b1;
        end else begin
          n      = (num == 8'd0) ? 256 : num;
          cb     = (vl == VL_32) ? 4 : (vl == VL_16) ? 2 : 1;
          data_n = (n * (vn + 1) * cb + 3) / 4;
        end
      end else begin
        // a code outside every known command
        case ($urandom_range(0, 3))
          0:       cmd = 7'h08 + 7'($urandom_range(0, 7));
          1:       cmd = 7'h18 + 7'($urandom_range(0, 7));
          2:       cmd = CMD_STMASK + 7'($urandom_range(1, 15));
          default: cmd = 7'h32 + 7'($urandom_range(0, 45));
        endcase
        halting = 1'b1;
      end
      frame.insert(frame.size(), cmd_word(cmd, num, hi, lo));
      repeat (data_n) frame.insert(frame.size(), $urandom);
      last_data = data_n;
    end
    if (halting) begin
      // trailing words that the walk should only mark as ignored
      repeat ($urandom_range(0, 3)) frame.insert(frame.size(), $urandom);
    end else if (last_data > 0 && $urandom_range(0, 99) < 10) begin
      repeat ($urandom_range(1, last_data)) void'(frame.pop_back());
      cut_streams++;
    end
  endtask

  initial begin
    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_word  = '0;
    in_last  = 1'b0;
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;

    // Directed streams: field extremes, each command family and every halt.
    frame = '{32'h0000_0000};                      // bare NOP, all zeros
    send_frame();
    frame = '{32'h80FF_FFFF, 32'h17FF_FFFF};       // NOP with interrupt bit, last immediate
    send_frame();
    frame = '{32'h0100_0000, 32'hA000_0000, 32'hFFFF_FFFF}; // cycle 256/256, mask, its word
    send_frame();
    frame = '{32'h3000_0000, 32'h0000_0000, 32'hFFFF_FFFF, 32'h5A5A_5A5A, 32'hA5A5_A5A5};
    send_frame();
    frame = '{32'h6501_0000, 32'h1234_5678};       // one uv element, one payload word
    send_frame();
    frame = '{32'h6F01_0000, 32'hDEAD_BEEF};       // packed V4_5 halts, next word ignored
    send_frame();
    frame = '{32'h0800_0000, 32'hFFFF_FFFF};       // unknown command halts
    send_frame();
    frame = '{32'h0100_0201};                      // fill-mode cycle setting
    send_frame();
    frame = '{32'h3100_0000};                      // column cut short at its command word
    send_frame();
    frame = '{32'h6A03_0000, 32'h0000_0001};       // colours cut short inside the payload
    send_frame();
    frame = '{32'hEC00_0000, 32'h0000_0000};       // 256 anchors: the longest payload
    send_frame();
    frame = '{32'h69FF_0000};                      // 255 positions cut at the command
    send_frame();
    drain_labels();

    // Random streams; pause now and then until every label is back.
    while (words_sent < WORD_TARGET) begin
      build_stream();
      send_frame();
      if (streams_sent % 25 == 0) drain_labels();
    end
    in_valid <= 1'b0;

    // Let the last labels come home.
    while (labels_pending != 0) @(negedge clk);
    repeat (8) @(negedge clk);

    $display("Covered %0d request words in %0d streams: %0d cut short, %0d noise, %0d drains",
             words_sent, streams_sent, cut_streams, noise_streams, drains);
    if (mismatches == 0 && labels_pending == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
